// ===== design/sjed_pkg.sv =====
// Package for the skeleton endpoint and junction detector.
// Holds sizes, register codes, window masks and the structs passed between modules.
// Depends on nothing; imported by sjed_front, sjed_window and the top level.
package sjed_pkg;

   // Largest frame that the line buffers hold.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Field and register widths.
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS      = 12;
   localparam int SAMPLE_BITS    = 16;
   localparam int CNT_BITS       = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // One line buffer entry: bit 1 is the row two above, bit 0 the row above.
   localparam int LINE_BITS = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FG_THRESHOLD = 2'd2;

   // Register reset values.
   localparam logic [SIZE_BITS-1:0]   RESET_WIDTH     = 12'd640;
   localparam logic [SIZE_BITS-1:0]   RESET_HEIGHT    = 12'd480;
   localparam logic [SAMPLE_BITS-1:0] RESET_THRESHOLD = 16'd128;

   // 3x3 window: three bits per column, oldest column in bits 0..2, top row first.
   localparam logic [8:0] MASK_LEFT   = 9'h007;
   localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
   localparam logic [8:0] MASK_TOP    = 9'h049;
   localparam logic [8:0] MASK_BOTTOM = 9'h124;

   // A foreground pixel is a vertex when its neighbor count differs from this.
   localparam logic [CNT_BITS-1:0] LINE_NEIGHBORS = 4'd2;

   // Pixel held between the line buffer read and the window update.
   typedef struct packed {
      logic                 valid;
      logic [COL_BITS-1:0]  addr;
      logic                 pixel;
      logic                 has_result;
      logic [COL_BITS-1:0]  px;
      logic [ROW_BITS-1:0]  py;
      logic                 at_left;
      logic                 at_right;
      logic                 at_top;
      logic                 at_bottom;
      logic                 frame_end;
      logic                 fwd;
      logic [LINE_BITS-1:0] fwd_data;
   } stage_type;

   // Line buffer write request.
   typedef struct packed {
      logic                 en;
      logic [COL_BITS-1:0]  addr;
      logic [LINE_BITS-1:0] data;
   } line_wr_type;

endpackage

// ===== design/sjed_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the line buffers of the detector.
// Depends on nothing.
module sjed_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sjed_front.sv =====
// Input side of the detector: configuration registers, raster position, line
// buffer read issue and the stage register that waits for the read data.
// Depends on sjed_pkg.
module sjed_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [sjed_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  logic                              csr_write,
   input  logic [sjed_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sjed_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                              s1_go,
   input  sjed_pkg::line_wr_type             line_wr,
   output logic                              rd_en,
   output logic [sjed_pkg::COL_BITS-1:0]     rd_addr,
   output sjed_pkg::stage_type               s1,
   output logic                              cfg_restart
);
   import sjed_pkg::*;

   logic [SIZE_BITS-1:0]   width_ff, width_in;
   logic [SIZE_BITS-1:0]   height_ff, height_in;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;
   logic [COL_BITS-1:0]    cx_ff, cx_in;
   logic [SIZE_BITS-1:0]   cy_ff, cy_in;
   stage_type              s1_ff, s1_in;

   logic [SIZE_BITS-1:0]   w_eff, h_eff, w_m1, h_m1;
   logic [COL_BITS-1:0]    cx_eff;
   logic [SIZE_BITS-1:0]   py_full;
   logic                   is_col0;
   logic                   accept;
   stage_type              stage_new;

   // Register values outside the legal range are clamped into it.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_BITS'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = SIZE_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = SIZE_BITS'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = SIZE_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      w_m1 = w_eff - SIZE_BITS'(1);
      h_m1 = h_eff - SIZE_BITS'(1);
   end

   // Input handshake: take a transaction when the stage register is free or moving on.
   assign req_ready = !s1_ff.valid || s1_go;
   assign accept    = req_valid && req_ready;

   // Position of the incoming pixel and of the pixel it completes.
   always_comb begin
      cx_eff  = (SIZE_BITS'(cx_ff) >= w_eff) ? '0 : cx_ff;
      is_col0 = (cx_eff == '0);
      stage_new            = '0;
      stage_new.valid      = 1'b1;
      stage_new.addr       = cx_eff;
      stage_new.pixel      = !req_action && (req_sample > thr_ff);
      if (is_col0) begin
         stage_new.has_result = (cy_ff >= SIZE_BITS'(2));
         stage_new.px         = w_m1[COL_BITS-1:0];
         py_full              = cy_ff - SIZE_BITS'(2);
      end else begin
         stage_new.has_result = (cy_ff >= SIZE_BITS'(1));
         stage_new.px         = cx_eff - COL_BITS'(1);
         py_full              = cy_ff - SIZE_BITS'(1);
      end
      stage_new.py        = py_full[ROW_BITS-1:0];
      stage_new.at_left   = (stage_new.px == '0);
      stage_new.at_right  = (SIZE_BITS'(stage_new.px) == w_m1);
      stage_new.at_top    = (py_full == '0);
      stage_new.at_bottom = (py_full == h_m1);
      stage_new.frame_end = stage_new.has_result && stage_new.at_right
                            && stage_new.at_bottom;
      // The entry written this cycle by the stage ahead is not yet in the RAM.
      stage_new.fwd       = line_wr.en && (line_wr.addr == cx_eff);
      stage_new.fwd_data  = line_wr.data;
   end

   // Line buffer read for the incoming pixel.
   assign rd_en   = accept;
   assign rd_addr = cx_eff;

   // Configuration writes; a size change restarts the frame.
   assign cfg_restart = csr_write
                        && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = csr_data[SIZE_BITS-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_data[SIZE_BITS-1:0];
            end
            CSR_FG_THRESHOLD: begin
               thr_in = csr_data[SAMPLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Raster position advance, wrapping at the row end and restarting at frame end.
   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (cfg_restart) begin
         cx_in = '0;
         cy_in = '0;
      end else if (accept) begin
         if (stage_new.frame_end) begin
            cx_in = '0;
            cy_in = '0;
         end else if (SIZE_BITS'(cx_eff) == w_m1) begin
            cx_in = '0;
            cy_in = cy_ff + SIZE_BITS'(1);
         end else begin
            cx_in = cx_eff + COL_BITS'(1);
         end
      end
   end

   // Stage register waiting for the line buffer data.
   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in = stage_new;
      end else if (s1_go) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         thr_ff    <= RESET_THRESHOLD;
         cx_ff     <= '0;
         cy_ff     <= '0;
         s1_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         s1_ff     <= s1_in;
      end
   end

   assign s1 = s1_ff;

   // The input only stalls behind a held pixel.
   a_stall_needs_pixel: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_ff.valid)
      else $error("input stalled with an empty stage register");

   // An accepted transaction always lands in the stage register.
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_ff.valid)
      else $error("accepted transaction did not reach the stage register");

   // A frame end is only marked on a pixel that gives a result.
   a_frame_end_has_result: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.frame_end |-> s1_ff.has_result && s1_ff.at_right)
      else $error("frame end marked on a pixel without a result");

endmodule

// ===== design/sjed_window.sv =====
// Window side of the detector: line buffer write-back, 3x3 window shift,
// border masking, neighbor count and the result register.
// Depends on sjed_pkg.
module sjed_window (
   input  logic                               clock,
   input  logic                               reset,
   input  sjed_pkg::stage_type                s1,
   input  logic [sjed_pkg::LINE_BITS-1:0]     ram_q,
   input  logic                               cfg_restart,
   output logic                               s1_go,
   output sjed_pkg::line_wr_type              line_wr,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sjed_pkg::COL_BITS-1:0]      rsp_column,
   output logic [sjed_pkg::ROW_BITS-1:0]      rsp_row,
   output logic                               rsp_foreground,
   output logic [sjed_pkg::CNT_BITS-1:0]      rsp_neighbor_count,
   output logic                               rsp_is_vertex,
   output logic                               rsp_frame_end
);
   import sjed_pkg::*;

   logic [8:0]           window_ff, window_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_BITS-1:0]  column_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic                 fg_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 vertex_ff;
   logic                 frame_end_ff;

   logic [LINE_BITS-1:0] line_rd;
   logic [2:0]           newcol;
   logic [8:0]           win_next;
   logic [8:0]           win_masked;
   logic [CNT_BITS-1:0]  count;
   logic                 out_free;
   logic                 load;

   // Line buffer data, taking the forwarded entry when the read raced a write.
   assign line_rd = s1.fwd ? s1.fwd_data : ram_q;
   assign newcol  = {s1.pixel, line_rd[0], line_rd[1]};
   assign win_next = {newcol, window_ff[8:3]};

   // The stage moves on when the result register can take a transaction.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_go    = s1.valid && out_free;
   assign load     = s1_go && s1.has_result;

   // Write back: the row above moves up, the new pixel becomes the row above.
   always_comb begin
      line_wr.en   = s1_go;
      line_wr.addr = s1.addr;
      line_wr.data = {line_rd[0], s1.pixel};
   end

   // Neighbors outside the frame count as background.
   always_comb begin
      win_masked = win_next;
      if (s1.at_left) begin
         win_masked = win_masked & ~MASK_LEFT;
      end
      if (s1.at_right) begin
         win_masked = win_masked & ~MASK_RIGHT;
      end
      if (s1.at_top) begin
         win_masked = win_masked & ~MASK_TOP;
      end
      if (s1.at_bottom) begin
         win_masked = win_masked & ~MASK_BOTTOM;
      end
   end

   // Count of the eight neighbors.
   always_comb begin
      count = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + CNT_BITS'(win_masked[i]);
         end
      end
   end

   // Window shift; cleared on a size change and after the last pixel of a frame.
   always_comb begin
      window_in = window_ff;
      if (cfg_restart) begin
         window_in = '0;
      end else if (s1_go) begin
         window_in = s1.frame_end ? '0 : win_next;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         column_ff    <= s1.px;
         row_ff       <= s1.py;
         fg_ff        <= win_masked[4];
         count_ff     <= count;
         vertex_ff    <= win_masked[4] && (count != LINE_NEIGHBORS);
         frame_end_ff <= s1.frame_end;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column         = column_ff;
   assign rsp_row            = row_ff;
   assign rsp_foreground     = fg_ff;
   assign rsp_neighbor_count = count_ff;
   assign rsp_is_vertex      = vertex_ff;
   assign rsp_frame_end      = frame_end_ff;

   // Eight neighbors at most.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_neighbor_count <= CNT_BITS'(8))
      else $error("neighbor count above eight");

   // Only a foreground pixel can be a vertex.
   a_vertex_is_fg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_vertex |-> rsp_foreground)
      else $error("vertex flagged on a background pixel");

   // The line buffer is written exactly when the stage moves on.
   a_write_with_stage: assert property (@(posedge clock) disable iff (reset)
      line_wr.en |-> s1.valid && out_free)
      else $error("line buffer written without a moving pixel");

endmodule

// ===== design/skeleton_junction_endpoint_detect_top.sv =====
// Top level of the skeleton endpoint and junction detector.
// Depends on sjed_pkg, sjed_front, sjed_ram and sjed_window.
//
// Usage:
//   req_* takes one sample per transaction in raster order; req_action set
//   marks a padding transaction, treated as background. A pixel is classified
//   once its 3x3 neighborhood is in, that is width+1 transactions later, so
//   the host appends width+1 padding transactions after the last pixel.
//   rsp_* delivers one transaction per classified pixel: position, foreground
//   flag, neighbor count, vertex flag and a frame end mark on the last pixel.
//   After the frame end result the next transaction is pixel (0,0).
//   csr_* writes frame_width, frame_height and fg_threshold, only while idle;
//   a size write restarts the frame, line buffer contents are kept.
//   Throughput is one transaction per cycle while rsp_ready is high. An accepted
//   transaction loads the stage register and the line buffer read; its result then
//   loads the result register, once that register is free.
//   When rsp_ready is low the result register holds, the stage register takes
//   one more transaction, then req_ready drops until the result is taken.
//   Reset restores the register defaults (640 x 480, threshold 128) and an
//   empty pipeline; the line buffers are not cleared and need no clearing pass.
module skeleton_junction_endpoint_detect_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [sjed_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sjed_pkg::COL_BITS-1:0]        rsp_column,
   output logic [sjed_pkg::ROW_BITS-1:0]        rsp_row,
   output logic                                 rsp_foreground,
   output logic [sjed_pkg::CNT_BITS-1:0]        rsp_neighbor_count,
   output logic                                 rsp_is_vertex,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_write,
   input  logic [sjed_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sjed_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import sjed_pkg::*;

   stage_type            s1;
   line_wr_type          line_wr;
   logic                 s1_go;
   logic                 cfg_restart;
   logic                 rd_en;
   logic [COL_BITS-1:0]  rd_addr;
   logic [LINE_BITS-1:0] ram_q;

   // Position tracking, configuration and line buffer read issue.
   sjed_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_sample  (req_sample),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .s1_go       (s1_go),
      .line_wr     (line_wr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .s1          (s1),
      .cfg_restart (cfg_restart)
   );

   // Both line buffers share one RAM, two bits per column.
   sjed_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (line_wr.en),
      .wr_addr (line_wr.addr),
      .wr_data (line_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Window, classification and result register.
   sjed_window u_window (
      .clock              (clock),
      .reset              (reset),
      .s1                 (s1),
      .ram_q              (ram_q),
      .cfg_restart        (cfg_restart),
      .s1_go              (s1_go),
      .line_wr            (line_wr),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column         (rsp_column),
      .rsp_row            (rsp_row),
      .rsp_foreground     (rsp_foreground),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_is_vertex      (rsp_is_vertex),
      .rsp_frame_end      (rsp_frame_end)
   );

endmodule
